@@ rtl/haptic_channel_analyzer_defines.svh @@
// Assertion macros for the haptic channel analyzer checker.
// No dependencies; included by the checker file.
`ifndef HAPTIC_CHANNEL_ANALYZER_DEFINES_SVH
`define HAPTIC_CHANNEL_ANALYZER_DEFINES_SVH

// same-cycle implication, clocked on clock, off while reset is high
`define HCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hca_pkg.sv @@
// Shared constants and types of the haptic channel analyzer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hca_pkg;

   localparam int STATE_FRAC_BITS_DEF = 16;
   localparam int ACC_WIDTH_DEF       = 48;
   localparam int SPLIT_LO            = 20;
   localparam int OUT_ACC_W           = 48;
   localparam int CNT_W               = 16;
   localparam int SAMPLE_W            = 16;
   localparam int HYST_W              = 15;
   // low part is 18 bits signed, high part 19 bits, so squares fit 38 bits
   localparam int LOW_W               = 18;
   localparam int HIGH_W              = 19;
   localparam int SQ_W                = 2 * HIGH_W;

   localparam logic [HYST_W-1:0] HYST_RESET = 15'd64;

   // Q2.30 coefficients, feedback terms negated
   localparam logic signed [31:0] COEF_B0  = 32'sd29221;
   localparam logic signed [31:0] COEF_B1  = 32'sd58441;
   localparam logic signed [31:0] COEF_NA1 = 32'sd2131582238;
   localparam logic signed [31:0] COEF_NA2 = -32'sd1057957296;

   localparam logic CSR_SPLIT_MODE = 1'b0;
   localparam logic CSR_HYST       = 1'b1;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // what the registered product feeds
   localparam logic [2:0] KIND_B   = 3'd0;
   localparam logic [2:0] KIND_AL  = 3'd1;
   localparam logic [2:0] KIND_AH  = 3'd2;
   localparam logic [2:0] KIND_SQX = 3'd3;
   localparam logic [2:0] KIND_SQL = 3'd4;
   localparam logic [2:0] KIND_SQH = 3'd5;

   typedef struct packed {
      logic start;
      logic clear;
   } lane_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/haptic_channel_analyzer.sv @@
// Haptic channel analyzer: an accepted frame stalls the input until both lanes finish
// (one shared multiplier per lane runs six filter products and three squares,
// left and right in parallel lanes), so a new frame is taken only after the last is done.
// A tick waits while a frame is in progress or an earlier result is still held; its
// result shows in the output register the cycle after acceptance.
// Synchronous active-high reset clears totals, history, polarity and config.
`timescale 1ns / 1ps
`default_nettype none

module haptic_channel_analyzer #(
   parameter int STATE_FRAC_BITS = hca_pkg::STATE_FRAC_BITS_DEF,
   parameter int ACC_WIDTH       = hca_pkg::ACC_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [hca_pkg::HYST_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic signed [hca_pkg::SAMPLE_W-1:0] req_sample_left,
   input  logic signed [hca_pkg::SAMPLE_W-1:0] req_sample_right,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_energy_right,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_low_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_low_energy_right,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_high_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_high_energy_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_crossings_left,
   output logic [hca_pkg::CNT_W-1:0]     rsp_crossings_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_active_left,
   output logic [hca_pkg::CNT_W-1:0]     rsp_active_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_frame_count
);
   import hca_pkg::*;

   logic              split_ff;
   logic [HYST_W-1:0] hyst_ff;
   lane_ctrl_type     ctrl;
   logic              done_l, done_r;
   logic [ACC_WIDTH-1:0] en_l, en_r, le_l, le_r, he_l, he_r;
   logic [CNT_W-1:0]  cr_l, cr_r, ac_l, ac_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= 1'b0;
         hyst_ff  <= HYST_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPLIT_MODE: split_ff <= csr_wdata[0];
            CSR_HYST:       hyst_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   hca_lane #(.STATE_FRAC_BITS(STATE_FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_lane_l (
      .clock, .reset, .ctrl, .sample(req_sample_left), .split_mode(split_ff),
      .hysteresis(hyst_ff), .done(done_l), .energy(en_l), .low_energy(le_l),
      .high_energy(he_l), .crossings(cr_l), .active(ac_l)
   );

   hca_lane #(.STATE_FRAC_BITS(STATE_FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_lane_r (
      .clock, .reset, .ctrl, .sample(req_sample_right), .split_mode(split_ff),
      .hysteresis(hyst_ff), .done(done_r), .energy(en_r), .low_energy(le_r),
      .high_energy(he_r), .crossings(cr_r), .active(ac_r)
   );

   hca_merge #(.ACC_WIDTH(ACC_WIDTH)) u_merge (
      .clock, .reset, .req_valid, .req_type, .req_stall, .ctrl,
      .lane_done(done_l && done_r),
      .en_l, .en_r, .le_l, .le_r, .he_l, .he_r, .cr_l, .cr_r, .ac_l, .ac_r,
      .rsp_valid, .rsp_stall,
      .rsp_energy_left, .rsp_energy_right, .rsp_low_energy_left, .rsp_low_energy_right,
      .rsp_high_energy_left, .rsp_high_energy_right, .rsp_crossings_left,
      .rsp_crossings_right, .rsp_active_left, .rsp_active_right, .rsp_frame_count
   );

endmodule

`default_nettype wire

@@ rtl/hca_lane.sv @@
// One channel lane: biquad low-pass on a shared multiplier, split energies,
// activity and hysteresis crossing counts. Depends on hca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hca_lane #(
   parameter int STATE_FRAC_BITS = 16,
   parameter int ACC_WIDTH       = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hca_pkg::lane_ctrl_type        ctrl,
   input  logic signed [hca_pkg::SAMPLE_W-1:0] sample,
   input  logic                          split_mode,
   input  logic [hca_pkg::HYST_W-1:0]    hysteresis,
   output logic                          done,
   output logic [ACC_WIDTH-1:0]          energy,
   output logic [ACC_WIDTH-1:0]          low_energy,
   output logic [ACC_WIDTH-1:0]          high_energy,
   output logic [hca_pkg::CNT_W-1:0]     crossings,
   output logic [hca_pkg::CNT_W-1:0]     active
);
   import hca_pkg::*;

   localparam int YBITS = 18 + STATE_FRAC_BITS;
   localparam int YHW   = YBITS - SPLIT_LO;
   localparam int OPW   = (YHW > 21) ? YHW : 21;
   localparam int PW    = 32 + OPW;
   localparam int AW    = YBITS + 34;

   localparam logic [3:0] ST_B0   = 4'd0;
   localparam logic [3:0] ST_B1   = 4'd1;
   localparam logic [3:0] ST_A1L  = 4'd2;
   localparam logic [3:0] ST_A2L  = 4'd3;
   localparam logic [3:0] ST_A1H  = 4'd4;
   localparam logic [3:0] ST_A2H  = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_Y    = 4'd7;
   localparam logic [3:0] ST_SPL  = 4'd8;
   localparam logic [3:0] ST_SQX  = 4'd9;
   localparam logic [3:0] ST_SQL  = 4'd10;
   localparam logic [3:0] ST_SQH  = 4'd11;
   localparam logic [3:0] ST_LAST = 4'd12;

   localparam logic signed [AW-1:0] YMAX = {{(AW-YBITS+1){1'b0}}, {(YBITS-1){1'b1}}};
   localparam logic signed [AW-1:0] YMIN = ~YMAX;
   localparam logic signed [AW-1:0] RND  = AW'(64'd1 << 29);
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
   localparam logic [CNT_W-1:0]     CNT_MAX = '1;

   logic                      run_ff;
   logic [3:0]                step_ff;
   logic signed [SAMPLE_W-1:0] x_ff, x1_ff, x2_ff;
   logic signed [YBITS-1:0]   y_ff, y1_ff, y2_ff, y_in;
   logic signed [AW-1:0]      acc_ff, acc_sh;
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic [2:0]                kind_ff, kind_in;
   logic                      pvld_ff, mul_en;
   logic signed [31:0]        coef;
   logic signed [OPW-1:0]     op;
   logic signed [LOW_W-1:0]   lo_ff;
   logic signed [HIGH_W-1:0]  hi_ff;
   logic signed [YBITS-1:0]   lo_q;
   logic signed [YBITS:0]     hnum, hi_q;
   logic [ACC_WIDTH-1:0]      en_ff, le_ff, he_ff, tgt;
   logic [ACC_WIDTH:0]        sum_wide;
   logic [ACC_WIDTH-1:0]      sum_sat;
   logic [CNT_W-1:0]          cross_ff, act_ff;
   logic                      pos_ff;
   logic signed [HIGH_W:0]    v, h;
   logic                      above, below;

   // operand select for the shared multiplier
   always_comb begin
      coef    = '0;
      op      = '0;
      mul_en  = 1'b0;
      kind_in = KIND_B;
      case (step_ff)
         ST_B0: begin
            coef = COEF_B0; op = OPW'(x_ff) + OPW'(x2_ff); mul_en = 1'b1; kind_in = KIND_B;
         end
         ST_B1: begin
            coef = COEF_B1; op = OPW'(x1_ff); mul_en = 1'b1; kind_in = KIND_B;
         end
         ST_A1L: begin
            coef = COEF_NA1; op = OPW'({1'b0, y1_ff[SPLIT_LO-1:0]});
            mul_en = 1'b1; kind_in = KIND_AL;
         end
         ST_A2L: begin
            coef = COEF_NA2; op = OPW'({1'b0, y2_ff[SPLIT_LO-1:0]});
            mul_en = 1'b1; kind_in = KIND_AL;
         end
         ST_A1H: begin
            coef = COEF_NA1; op = OPW'(y1_ff >>> SPLIT_LO); mul_en = 1'b1; kind_in = KIND_AH;
         end
         ST_A2H: begin
            coef = COEF_NA2; op = OPW'(y2_ff >>> SPLIT_LO); mul_en = 1'b1; kind_in = KIND_AH;
         end
         ST_SQX: begin
            coef = 32'(x_ff); op = OPW'(x_ff); mul_en = 1'b1; kind_in = KIND_SQX;
         end
         ST_SQL: begin
            coef = 32'(lo_ff); op = OPW'(lo_ff); mul_en = 1'b1; kind_in = KIND_SQL;
         end
         ST_SQH: begin
            coef = 32'(hi_ff); op = OPW'(hi_ff); mul_en = 1'b1; kind_in = KIND_SQH;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = PW'(coef) * PW'(op);

   // output of the filter: round already folded into acc, floor shift, saturate
   assign acc_sh = acc_ff >>> 30;
   always_comb begin
      if (acc_sh > YMAX)
         y_in = YMAX[YBITS-1:0];
      else if (acc_sh < YMIN)
         y_in = YMIN[YBITS-1:0];
      else
         y_in = acc_sh[YBITS-1:0];
   end

   // divide by 2^F, truncating toward zero
   assign lo_q = (y_ff >>> STATE_FRAC_BITS)
                 + YBITS'(y_ff[YBITS-1] && (|y_ff[STATE_FRAC_BITS-1:0]));
   assign hnum = ((YBITS+1)'(x_ff) <<< STATE_FRAC_BITS) - (YBITS+1)'(y_ff);
   assign hi_q = (hnum >>> STATE_FRAC_BITS)
                 + (YBITS+1)'(hnum[YBITS] && (|hnum[STATE_FRAC_BITS-1:0]));

   // energy target and saturating add
   always_comb begin
      case (kind_ff)
         KIND_SQX: tgt = en_ff;
         KIND_SQL: tgt = le_ff;
         default:  tgt = he_ff;
      endcase
   end
   assign sum_wide = {1'b0, tgt} + (ACC_WIDTH+1)'(prod_ff[SQ_W-1:0]);
   assign sum_sat  = sum_wide[ACC_WIDTH] ? ACC_MAX : sum_wide[ACC_WIDTH-1:0];

   // hysteresis decision
   assign v     = split_mode ? (HIGH_W+1)'(hi_ff) : (HIGH_W+1)'(x_ff);
   assign h     = (HIGH_W+1)'({1'b0, hysteresis});
   assign above = v > h;
   assign below = v < -h;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         step_ff  <= ST_B0;
         pvld_ff  <= 1'b0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
         en_ff    <= '0;
         le_ff    <= '0;
         he_ff    <= '0;
         cross_ff <= '0;
         act_ff   <= '0;
         pos_ff   <= 1'b1;
      end else begin
         pvld_ff <= run_ff && mul_en;
         if (ctrl.start) begin
            run_ff  <= 1'b1;
            step_ff <= ST_B0;
         end else if (run_ff) begin
            if (step_ff == ST_LAST) begin
               run_ff  <= 1'b0;
               step_ff <= ST_B0;
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end
         if (run_ff && step_ff == ST_Y) begin
            x2_ff <= x1_ff;
            x1_ff <= x_ff;
            y2_ff <= y1_ff;
            y1_ff <= y_in;
         end
         if (ctrl.clear) begin
            en_ff    <= '0;
            le_ff    <= '0;
            he_ff    <= '0;
            cross_ff <= '0;
            act_ff   <= '0;
         end else begin
            if (pvld_ff) begin
               case (kind_ff)
                  KIND_SQX: en_ff <= sum_sat;
                  KIND_SQL: le_ff <= sum_sat;
                  KIND_SQH: he_ff <= sum_sat;
                  default: ;
               endcase
            end
            if (run_ff && step_ff == ST_SQX) begin
               if ((above || below) && act_ff != CNT_MAX)
                  act_ff <= act_ff + 1'b1;
               if ((pos_ff && below) || (!pos_ff && above)) begin
                  pos_ff <= !pos_ff;
                  if (cross_ff != CNT_MAX)
                     cross_ff <= cross_ff + 1'b1;
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff   <= sample;
         acc_ff <= RND;
      end else if (pvld_ff) begin
         case (kind_ff)
            KIND_B:  acc_ff <= acc_ff + (AW'(prod_ff) <<< STATE_FRAC_BITS);
            KIND_AL: acc_ff <= acc_ff + AW'(prod_ff);
            KIND_AH: acc_ff <= acc_ff + (AW'(prod_ff) <<< SPLIT_LO);
            default: ;
         endcase
      end
      if (mul_en) begin
         prod_ff <= prod_in;
         kind_ff <= kind_in;
      end
      if (run_ff && step_ff == ST_Y)
         y_ff <= y_in;
      if (run_ff && step_ff == ST_SPL) begin
         lo_ff <= LOW_W'(lo_q);
         hi_ff <= HIGH_W'(hi_q);
      end
   end

   assign done        = run_ff && step_ff == ST_LAST;
   assign energy      = en_ff;
   assign low_energy  = le_ff;
   assign high_energy = he_ff;
   assign crossings   = cross_ff;
   assign active      = act_ff;

endmodule

`default_nettype wire

@@ rtl/hca_merge.sv @@
// Merging stage: transaction control, frame counter and the result register
// that gathers both lanes' totals on a tick. Depends on hca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hca_merge #(
   parameter int ACC_WIDTH = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_type,
   output logic                          req_stall,
   output hca_pkg::lane_ctrl_type        ctrl,
   input  logic                          lane_done,
   input  logic [ACC_WIDTH-1:0]          en_l, en_r, le_l, le_r, he_l, he_r,
   input  logic [hca_pkg::CNT_W-1:0]     cr_l, cr_r, ac_l, ac_r,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_energy_right,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_low_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_low_energy_right,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_high_energy_left,
   output logic [hca_pkg::OUT_ACC_W-1:0] rsp_high_energy_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_crossings_left,
   output logic [hca_pkg::CNT_W-1:0]     rsp_crossings_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_active_left,
   output logic [hca_pkg::CNT_W-1:0]     rsp_active_right,
   output logic [hca_pkg::CNT_W-1:0]     rsp_frame_count
);
   import hca_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic             busy_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] frames_ff;
   logic             accept, tick;

   // a frame waits while busy; a tick also waits while an earlier result is still held
   assign req_stall = busy_ff || (req_type == REQ_TICK && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && req_type == REQ_TICK;
   assign ctrl.start = accept && req_type == REQ_FRAME;
   assign ctrl.clear = tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= '0;
      end else begin
         if (ctrl.start)
            busy_ff <= 1'b1;
         else if (lane_done)
            busy_ff <= 1'b0;
         if (tick)
            frames_ff <= '0;
         else if (lane_done && frames_ff != CNT_MAX)
            frames_ff <= frames_ff + 1'b1;
         if (tick)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_energy_left       <= OUT_ACC_W'(en_l);
         rsp_energy_right      <= OUT_ACC_W'(en_r);
         rsp_low_energy_left   <= OUT_ACC_W'(le_l);
         rsp_low_energy_right  <= OUT_ACC_W'(le_r);
         rsp_high_energy_left  <= OUT_ACC_W'(he_l);
         rsp_high_energy_right <= OUT_ACC_W'(he_r);
         rsp_crossings_left    <= cr_l;
         rsp_crossings_right   <= cr_r;
         rsp_active_left       <= ac_l;
         rsp_active_right      <= ac_r;
         rsp_frame_count       <= frames_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/hca_checker.sv @@
// Port-level checker for the haptic channel analyzer, bound to the top level.
// Depends on haptic_channel_analyzer_defines.svh and hca_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "haptic_channel_analyzer_defines.svh"

module hca_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_type,
   input logic rsp_valid,
   input logic rsp_stall
);
   import hca_pkg::*;

   logic frame_acc, tick_acc;
   assign frame_acc = req_valid && !req_stall && req_type == REQ_FRAME;
   assign tick_acc  = req_valid && !req_stall && req_type == REQ_TICK;

   `HCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `HCA_ASSERT_NEXT(a_frame_busy, frame_acc, req_stall, "frame transaction not held busy")
   `HCA_ASSERT_NEXT(a_tick_rsp, tick_acc, rsp_valid, "tick produced no result")

endmodule

bind haptic_channel_analyzer hca_checker u_hca_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
);

`default_nettype wire

@@ bench/tb_haptic_channel_analyzer.sv @@
// Self-checking bench for haptic_channel_analyzer: directed table, then random
// frame windows under several settings, checked against an in-bench predictor.
// Depends on hca_pkg and the haptic_channel_analyzer RTL.
`timescale 1ns / 1ps

module tb_haptic_channel_analyzer;
   import hca_pkg::*;

   // window totals: sums are left, right, low left, low right, high left,
   // high right; counts are crossings l/r, active l/r, frames
   typedef struct {
      logic [47:0] sums [6];
      logic [15:0] counts [5];
   } window_totals_type;

   typedef struct {
      logic    kind;
      shortint left;
      shortint right;
      bit      empty_window;  // result known to be all zero
   } stim_row_type;

   localparam longint FILT_B0  = 29221;
   localparam longint FILT_B1  = 58441;
   localparam longint FILT_NA1 = 2131582238;
   localparam longint FILT_NA2 = -1057957296;
   localparam longint Y_MAX    = (longint'(1) <<< 33) - 1;
   localparam longint Y_MIN    = -(longint'(1) <<< 33);
   localparam longint ONE_FRAC = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_SPLIT_MODE;
   logic [HYST_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_FRAME;
   logic signed [SAMPLE_W-1:0] req_sample_left = '0;
   logic signed [SAMPLE_W-1:0] req_sample_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_ACC_W-1:0] rsp_energy_left, rsp_energy_right;
   logic [OUT_ACC_W-1:0] rsp_low_energy_left, rsp_low_energy_right;
   logic [OUT_ACC_W-1:0] rsp_high_energy_left, rsp_high_energy_right;
   logic [CNT_W-1:0] rsp_crossings_left, rsp_crossings_right;
   logic [CNT_W-1:0] rsp_active_left, rsp_active_right, rsp_frame_count;

   haptic_channel_analyzer u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_sample_left(req_sample_left), .req_sample_right(req_sample_right),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_energy_left(rsp_energy_left), .rsp_energy_right(rsp_energy_right),
      .rsp_low_energy_left(rsp_low_energy_left), .rsp_low_energy_right(rsp_low_energy_right),
      .rsp_high_energy_left(rsp_high_energy_left),
      .rsp_high_energy_right(rsp_high_energy_right),
      .rsp_crossings_left(rsp_crossings_left), .rsp_crossings_right(rsp_crossings_right),
      .rsp_active_left(rsp_active_left), .rsp_active_right(rsp_active_right),
      .rsp_frame_count(rsp_frame_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   bit          split_on;
   int          hysteresis;
   int          x_hist1 [2], x_hist2 [2];
   longint      y_hist1 [2], y_hist2 [2];
   bit          on_positive [2];
   logic [47:0] sum_acc [6];
   int          count_acc [5];

   window_totals_type expected_totals [$];
   int mismatch_count = 0;
   int results_seen = 0;
   int frames_sent = 0;
   int ticks_sent = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int stall_hold_cycles = 0;

   function automatic void clear_window();
      for (int i = 0; i < 6; i++) sum_acc[i] = '0;
      for (int i = 0; i < 5; i++) count_acc[i] = 0;
   endfunction

   function automatic void reset_analyzer_model();
      split_on = 1'b0;
      hysteresis = HYST_RESET;
      for (int c = 0; c < 2; c++) begin
         x_hist1[c] = 0;
         x_hist2[c] = 0;
         y_hist1[c] = 0;
         y_hist2[c] = 0;
         on_positive[c] = 1'b1;
      end
      clear_window();
   endfunction

   function automatic void add_saturating(int idx, longint value);
      logic [48:0] total;
      total = {1'b0, sum_acc[idx]} + 49'(value);
      sum_acc[idx] = total[48] ? '1 : total[47:0];
   endfunction

   function automatic void bump_count(int idx);
      if (count_acc[idx] < 65535) count_acc[idx]++;
   endfunction

   function automatic void analyze_channel(int ch, shortint x);
      logic signed [95:0] filt_acc;
      longint y, low_part, high_part, judged;
      filt_acc = (FILT_B0 * (longint'(x) + x_hist2[ch]) + FILT_B1 * x_hist1[ch]) * ONE_FRAC
                 + FILT_NA1 * y_hist1[ch] + FILT_NA2 * y_hist2[ch] + (longint'(1) <<< 29);
      filt_acc = filt_acc >>> 30;
      if (filt_acc > Y_MAX) y = Y_MAX;
      else if (filt_acc < Y_MIN) y = Y_MIN;
      else y = longint'(filt_acc);
      x_hist2[ch] = x_hist1[ch];
      x_hist1[ch] = x;
      y_hist2[ch] = y_hist1[ch];
      y_hist1[ch] = y;
      low_part = y / ONE_FRAC;
      high_part = (longint'(x) * ONE_FRAC - y) / ONE_FRAC;
      judged = split_on ? high_part : longint'(x);
      add_saturating(ch, longint'(x) * x);
      add_saturating(2 + ch, low_part * low_part);
      add_saturating(4 + ch, high_part * high_part);
      if (judged > hysteresis || judged < -hysteresis) bump_count(2 + ch);
      if ((on_positive[ch] && judged < -hysteresis) ||
          (!on_positive[ch] && judged > hysteresis)) begin
         on_positive[ch] = !on_positive[ch];
         bump_count(ch);
      end
   endfunction

   function automatic void predict_transaction(stim_row_type row);
      window_totals_type totals;
      if (row.kind == REQ_FRAME) begin
         analyze_channel(0, row.left);
         analyze_channel(1, row.right);
         bump_count(4);
         frames_sent++;
      end else begin
         for (int i = 0; i < 6; i++) totals.sums[i] = row.empty_window ? '0 : sum_acc[i];
         for (int i = 0; i < 5; i++)
            totals.counts[i] = row.empty_window ? '0 : 16'(count_acc[i]);
         expected_totals.push_back(totals);
         clear_window();
         ticks_sent++;
      end
   endfunction

   task automatic send_transaction(stim_row_type row);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= row.kind;
      req_sample_left <= row.left;
      req_sample_right <= row.right;
      do @(posedge clock); while (req_stall);
      predict_transaction(row);
   endtask

   task automatic send_frame(shortint l, shortint r);
      stim_row_type row;
      row = '{REQ_FRAME, l, r, 1'b0};
      send_transaction(row);
   endtask

   task automatic send_tick();
      stim_row_type row;
      row = '{REQ_TICK, 16'sd0, 16'sd0, 1'b0};
      row.left = shortint'($urandom());
      row.right = shortint'($urandom());
      send_transaction(row);
   endtask

   // frames cause no result, so allow the frame pipeline to empty as well
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(logic idx, int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= HYST_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_SPLIT_MODE) split_on = value[0];
      else hysteresis = value & 32'h7FFF;
   endtask

   function automatic shortint random_sample();
      int pick;
      int mag;
      pick = $urandom_range(0, 5);
      mag = hysteresis + $urandom_range(0, 2) - 1;
      case (pick)
         0: return shortint'($urandom());
         1: return shortint'($urandom_range(0, 400)) - 16'sd200;
         2: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
         3: begin
            if (mag > 32767) mag = 32767;
            if (mag < 0) mag = 0;
            return $urandom_range(0, 1) ? shortint'(mag) : -shortint'(mag);
         end
         default: return shortint'($urandom_range(0, 20000)) - 16'sd10000;
      endcase
   endfunction

   // mostly windows of frames closed by a tick; some bare ticks
   task automatic random_windows(int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
         repeat (len) send_frame(random_sample(), random_sample());
         send_tick();
         sent += len + 1;
      end
   endtask

   task automatic check_totals();
      window_totals_type got, want;
      string sum_names [6];
      string count_names [5];
      bit bad;
      sum_names = '{"energy_left", "energy_right", "low_energy_left", "low_energy_right",
                    "high_energy_left", "high_energy_right"};
      count_names = '{"crossings_left", "crossings_right", "active_left", "active_right",
                      "frame_count"};
      got.sums = '{rsp_energy_left, rsp_energy_right, rsp_low_energy_left,
                   rsp_low_energy_right, rsp_high_energy_left, rsp_high_energy_right};
      got.counts = '{rsp_crossings_left, rsp_crossings_right, rsp_active_left,
                     rsp_active_right, rsp_frame_count};
      results_seen++;
      if (expected_totals.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("ERROR: result with nothing expected");
         return;
      end
      want = expected_totals.pop_front();
      bad = 1'b0;
      for (int i = 0; i < 6; i++)
         if (got.sums[i] !== want.sums[i]) begin
            bad = 1'b1;
            if (mismatch_count < 10)
               $display("ERROR: result %0d %s expected %0d got %0d", results_seen,
                        sum_names[i], want.sums[i], got.sums[i]);
         end
      for (int i = 0; i < 5; i++)
         if (got.counts[i] !== want.counts[i]) begin
            bad = 1'b1;
            if (mismatch_count < 10)
               $display("ERROR: result %0d %s expected %0d got %0d", results_seen,
                        count_names[i], want.counts[i], got.counts[i]);
         end
      if (bad) mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_totals();
      if (stall_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      stim_row_type directed [$];
      reset_analyzer_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: raw-sample crossings, hysteresis 64
      directed = '{
         '{REQ_TICK,  16'sd0,      16'sd0,      1'b1},
         '{REQ_FRAME, 16'sd32767,  -16'sd32768, 1'b0},
         '{REQ_FRAME, -16'sd32768, 16'sd32767,  1'b0},
         '{REQ_FRAME, 16'sd0,      16'sd0,      1'b0},
         '{REQ_FRAME, 16'sd64,     -16'sd64,    1'b0},
         '{REQ_FRAME, 16'sd65,     -16'sd65,    1'b0},
         '{REQ_FRAME, -16'sd65,    16'sd65,     1'b0},
         '{REQ_FRAME, -16'sd64,    16'sd64,     1'b0},
         '{REQ_FRAME, 16'sd1,      -16'sd1,     1'b0},
         '{REQ_TICK,  16'sd0,      16'sd0,      1'b0},
         '{REQ_TICK,  16'sd0,      16'sd0,      1'b1},
         '{REQ_FRAME, 16'sd32767,  16'sd32767,  1'b0},
         '{REQ_FRAME, 16'sd32767,  16'sd32767,  1'b0},
         '{REQ_FRAME, 16'sd32767,  16'sd32767,  1'b0},
         '{REQ_FRAME, -16'sd32768, -16'sd32768, 1'b0},
         '{REQ_FRAME, -16'sd32768, -16'sd32768, 1'b0},
         '{REQ_FRAME, -16'sd1,     16'sd0,      1'b0},
         '{REQ_TICK,  16'sd0,      16'sd0,      1'b0}
      };
      foreach (directed[i]) send_transaction(directed[i]);
      wait_until_drained();

      // receiver holds off while ticks pile up behind the output register
      sender_idle_pct = 14;
      receiver_idle_pct = 59;
      stall_hold_cycles = 400;
      repeat (12) begin
         repeat ($urandom_range(0, 3)) send_frame(random_sample(), random_sample());
         send_tick();
      end
      wait_until_drained();

      write_register(CSR_SPLIT_MODE, 1);
      write_register(CSR_HYST, 0);
      random_windows(440);
      wait_until_drained();

      sender_idle_pct = 59;
      receiver_idle_pct = 14;
      write_register(CSR_SPLIT_MODE, 0);
      write_register(CSR_HYST, 32767);
      random_windows(440);
      wait_until_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_register(CSR_SPLIT_MODE, 1);
      write_register(CSR_HYST, $urandom_range(0, 32767));
      random_windows(300);
      wait_until_drained();
      write_register(CSR_HYST, $urandom_range(0, 300));
      random_windows(150);
      wait_until_drained();

      $display("Covered %0d frames and %0d window ticks, %0d window results checked,",
               frames_sent, ticks_sent, results_seen);
      $display("with split mode on and off, hysteresis 0 to 32767 and a long output stall.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hca_pkg.sv
rtl/hca_lane.sv
rtl/hca_merge.sv
rtl/haptic_channel_analyzer.sv
rtl/hca_checker.sv
bench/tb_haptic_channel_analyzer.sv
